### design/hbrd_pkg.sv
// shared types and constants for the h-bridge brake relay driver
// no dependencies; imported by every module of the block

package hbrd_pkg;

  // motor state codes
  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_BRAKE = 2'd1;
  localparam logic [1:0] ST_FWD   = 2'd2;
  localparam logic [1:0] ST_REV   = 2'd3;

  // configuration register indexes
  localparam logic [1:0] CFG_A_EN_LEVEL = 2'd0;
  localparam logic [1:0] CFG_B_EN_LEVEL = 2'd1;
  localparam logic [1:0] CFG_DUTY_RES   = 2'd2;
  localparam logic [1:0] CFG_BRAKE_DLY  = 2'd3;

  // 100 percent in q8.8
  localparam logic signed [15:0] FULL_SCALE_Q8 = 16'sd25600;

  // register reset values
  localparam logic [4:0]  RES_BITS_RST  = 5'd13;
  localparam logic [15:0] BRAKE_DLY_RST = 16'd300;

  typedef struct packed {
    logic [1:0]  motor_state;
    logic [31:0] now_ms;
  } cmd_t;

  typedef struct packed {
    logic pin_a_level;
    logic pin_b_level;
    logic relay_on;
    logic duty_updated;
  } drv_t;

endpackage

### design/hbridge_brake_relay_driver_top.sv
// H-bridge brake relay driver. Takes one command transaction per clock while the output
// side does not stall and returns one result transaction per command; a command passes
// three register stages before its result is offered. Stage one scales the Q8.8 duty by
// the maximum duty with a shift and subtract; stage two divides by 100 with one
// reciprocal multiplier and runs the brake relay sequencing against the stored relay
// start time; the third register holds the result. Each stage holds its item only while
// the stage after it is full and cannot take it, so the block keeps taking commands while
// a result waits, until every stage is full. Configuration writes take effect on the next
// edge and are meant for times when no command is in flight.
// depends on hbrd_pkg, hbrd_duty_pre, hbrd_div100, hbrd_brake_ctrl

module hbridge_brake_relay_driver_top
  import hbrd_pkg::*;
#(
  parameter int MAX_DUTY_BITS = 20
) (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  logic                                   cfg_we,
  input  logic [1:0]                             cfg_addr,
  input  logic [15:0]                            cfg_wdata,
  input  logic                                   in_tvalid,
  output logic                                   in_tready,
  input  logic [47:0]                            in_tdata,   // duty_q8, now_ms
  input  logic [1:0]                             in_tuser,   // motor_state
  output logic                                   out_tvalid,
  input  logic                                   out_tready,
  // pin_a_level, pin_b_level, relay_on, pwm_duty, duty_updated, zero fill
  output logic [((MAX_DUTY_BITS+11)/8)*8-1:0]    out_tdata
);

  localparam int QW = MAX_DUTY_BITS + 7;
  localparam int OW = ((MAX_DUTY_BITS + 11) / 8) * 8;
  localparam int DW = MAX_DUTY_BITS + 4;

  // configuration registers
  logic        a_en_r;
  logic        b_en_r;
  logic [4:0]  res_bits_r;
  logic [15:0] delay_r;
  logic [4:0]  bits_eff;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_en_r     <= 1'b1;
      b_en_r     <= 1'b1;
      res_bits_r <= RES_BITS_RST;
      delay_r    <= BRAKE_DLY_RST;
    end else if (cfg_we) begin
      case (cfg_addr)
        CFG_A_EN_LEVEL: a_en_r     <= cfg_wdata[0];
        CFG_B_EN_LEVEL: b_en_r     <= cfg_wdata[0];
        CFG_DUTY_RES:   res_bits_r <= cfg_wdata[4:0];
        CFG_BRAKE_DLY:  delay_r    <= cfg_wdata;
        default: ;
      endcase
    end
  end

  assign bits_eff = (res_bits_r > 5'(MAX_DUTY_BITS)) ? 5'(MAX_DUTY_BITS) : res_bits_r;

  // stage handshake
  logic out_v_r, s2_v_r, s1_v_r;
  logic out_rdy, s2_rdy, s1_rdy;
  logic step;

  assign out_rdy   = !out_v_r || out_tready;
  assign s2_rdy    = !s2_v_r || out_rdy;
  assign s1_rdy    = !s1_v_r || s2_rdy;
  assign in_tready = s1_rdy;
  assign step      = s2_v_r && out_rdy;

  // stage one: input register
  logic signed [15:0] s1_duty_r;
  cmd_t               s1_cmd_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
    end else if (s1_rdy) begin
      s1_v_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && s1_rdy) begin
      s1_duty_r            <= in_tdata[15:0];
      s1_cmd_r.now_ms      <= in_tdata[47:16];
      s1_cmd_r.motor_state <= in_tuser;
    end
  end

  logic [QW-1:0] pre_q;
  logic          pre_sat;
  logic          pre_np;

  hbrd_duty_pre #(.MAX_DUTY_BITS(MAX_DUTY_BITS)) u_pre (
    .duty_q8  (s1_duty_r),
    .bits_eff (bits_eff),
    .pre_q    (pre_q),
    .sat      (pre_sat),
    .nonpos   (pre_np)
  );

  // stage two: prescaled duty
  logic [QW-1:0] s2_q_r;
  logic          s2_sat_r;
  logic          s2_np_r;
  cmd_t          s2_cmd_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_v_r <= 1'b0;
    end else if (s2_rdy) begin
      s2_v_r <= s1_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_v_r && s2_rdy) begin
      s2_q_r   <= pre_q;
      s2_sat_r <= pre_sat;
      s2_np_r  <= pre_np;
      s2_cmd_r <= s1_cmd_r;
    end
  end

  logic [MAX_DUTY_BITS-1:0] scaled;
  logic [MAX_DUTY_BITS-1:0] pwm_duty;
  drv_t                     drv;

  hbrd_div100 #(.MAX_DUTY_BITS(MAX_DUTY_BITS)) u_div (
    .pre_q    (s2_q_r),
    .sat      (s2_sat_r),
    .nonpos   (s2_np_r),
    .bits_eff (bits_eff),
    .scaled   (scaled)
  );

  hbrd_brake_ctrl #(.MAX_DUTY_BITS(MAX_DUTY_BITS)) u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .step     (step),
    .cmd      (s2_cmd_r),
    .nonpos   (s2_np_r),
    .scaled   (scaled),
    .a_en     (a_en_r),
    .b_en     (b_en_r),
    .delay_ms (delay_r),
    .drv      (drv),
    .pwm_duty (pwm_duty)
  );

  // result register
  logic [OW-1:0] out_data_r;
  logic [DW-1:0] res_pack;

  assign res_pack = {drv.duty_updated, pwm_duty, drv.relay_on, drv.pin_b_level,
                     drv.pin_a_level};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else if (out_rdy) begin
      out_v_r <= s2_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      out_data_r <= OW'(res_pack);
    end
  end

  assign out_tvalid = out_v_r;
  assign out_tdata  = out_data_r;

endmodule

### design/hbrd_duty_pre.sv
// duty prescale: duty * (2^bits - 1) as shift and subtract, then drop the q8 fraction
// depends on hbrd_pkg

module hbrd_duty_pre
  import hbrd_pkg::*;
#(
  parameter int MAX_DUTY_BITS = 20
) (
  input  logic signed [15:0]         duty_q8,
  input  logic [4:0]                 bits_eff,
  output logic [MAX_DUTY_BITS+6:0]   pre_q,
  output logic                       sat,
  output logic                       nonpos
);

  localparam int XW = MAX_DUTY_BITS + 15;

  logic [XW-1:0] d_ext;
  logic [XW-1:0] prod;

  always_comb begin
    d_ext  = XW'(duty_q8[14:0]);
    prod   = (d_ext << bits_eff) - d_ext;
    pre_q  = prod[XW-1:8];
    sat    = duty_q8 > FULL_SCALE_Q8;
    nonpos = duty_q8[15] || (duty_q8 == 16'sd0);
  end

endmodule

### design/hbrd_div100.sv
// divide prescaled duty by 100 with a reciprocal multiply, apply saturation, zero for non-positive duty
// depends on hbrd_pkg

module hbrd_div100
  import hbrd_pkg::*;
#(
  parameter int MAX_DUTY_BITS = 20
) (
  input  logic [MAX_DUTY_BITS+6:0]   pre_q,
  input  logic                       sat,
  input  logic                       nonpos,
  input  logic [4:0]                 bits_eff,
  output logic [MAX_DUTY_BITS-1:0]   scaled
);

  localparam int QW = MAX_DUTY_BITS + 7;
  localparam int MW = MAX_DUTY_BITS + 8;
  localparam int PW = QW + MW;
  localparam int SH = QW + 7;
  localparam logic [63:0] RECIP = ((64'd1 << SH) + 64'd99) / 64'd100;

  logic [PW-1:0]            prod;
  logic [MAX_DUTY_BITS:0]   mx_full;
  logic [MAX_DUTY_BITS-1:0] mx;

  always_comb begin
    prod    = PW'(pre_q) * PW'(RECIP[MW-1:0]);
    mx_full = ((MAX_DUTY_BITS+1)'(1) << bits_eff) - (MAX_DUTY_BITS+1)'(1);
    mx      = mx_full[MAX_DUTY_BITS-1:0];
    if (nonpos) begin
      scaled = '0;
    end else if (sat) begin
      scaled = mx;
    end else begin
      scaled = prod[SH +: MAX_DUTY_BITS];
    end
  end

endmodule

### design/hbrd_brake_ctrl.sv
// brake sequencing state, pin decode and applied duty register
// depends on hbrd_pkg

module hbrd_brake_ctrl
  import hbrd_pkg::*;
#(
  parameter int MAX_DUTY_BITS = 20
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       step,
  input  cmd_t                       cmd,
  input  logic                       nonpos,
  input  logic [MAX_DUTY_BITS-1:0]   scaled,
  input  logic                       a_en,
  input  logic                       b_en,
  input  logic [15:0]                delay_ms,
  output drv_t                       drv,
  output logic [MAX_DUTY_BITS-1:0]   pwm_duty
);

  logic                     waiting_r, waiting_nxt;
  logic [31:0]              start_r, start_nxt;
  logic [MAX_DUTY_BITS-1:0] duty_r, duty_nxt;
  logic [1:0]               st;
  logic [31:0]              elapsed;

  always_comb begin
    st          = nonpos ? ST_IDLE : cmd.motor_state;
    elapsed     = cmd.now_ms - start_r;
    waiting_nxt = (st == ST_BRAKE) ? waiting_r : 1'b0;
    start_nxt   = start_r;
    drv.pin_a_level  = a_en;
    drv.pin_b_level  = b_en;
    drv.duty_updated = 1'b0;
    case (st)
      ST_IDLE: begin
        drv.duty_updated = 1'b1;
      end
      ST_BRAKE: begin
        if (!waiting_r) begin
          waiting_nxt = 1'b1;
          start_nxt   = cmd.now_ms;
        end else if (elapsed > 32'(delay_ms)) begin
          drv.pin_a_level  = ~a_en;
          drv.pin_b_level  = ~b_en;
          drv.duty_updated = 1'b1;
        end
      end
      ST_FWD: begin
        drv.pin_b_level  = ~b_en;
        drv.duty_updated = 1'b1;
      end
      default: begin
        drv.pin_a_level  = ~a_en;
        drv.duty_updated = 1'b1;
      end
    endcase
    drv.relay_on = waiting_nxt;
    duty_nxt     = drv.duty_updated ? scaled : duty_r;
    pwm_duty     = duty_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      waiting_r <= 1'b0;
      start_r   <= '0;
      duty_r    <= '0;
    end else if (step) begin
      waiting_r <= waiting_nxt;
      start_r   <= start_nxt;
      duty_r    <= duty_nxt;
    end
  end

endmodule

### tb/hbridge_brake_relay_driver_top_tb.sv
// testbench for hbridge_brake_relay_driver_top: directed, config sweep, no-idle, random and backpressure tests
// predicts pin levels, relay drive, pwm duty and duty_updated per command and checks every result transaction
// depends on hbrd_pkg and hbridge_brake_relay_driver_top
`timescale 1ns / 1ps

module hbridge_brake_relay_driver_top_tb
  import hbrd_pkg::*;
();

  localparam int MAX_DUTY_BITS = 20;
  localparam int OUT_W = ((MAX_DUTY_BITS + 11) / 8) * 8;
  localparam int HOLD_CYCLES = 300;

  typedef struct {
    logic        pin_a;
    logic        pin_b;
    logic        relay;
    logic [19:0] duty;
    logic        upd;
  } bridge_out_t;

  logic             clk;
  logic             rst_n;
  logic             cfg_we;
  logic [1:0]       cfg_addr;
  logic [15:0]      cfg_wdata;
  logic             in_tvalid;
  logic             in_tready;
  logic [47:0]      in_tdata;
  logic [1:0]       in_tuser;
  logic             out_tvalid;
  logic             out_tready;
  logic [OUT_W-1:0] out_tdata;

  logic idle_on;
  int   hold_req;
  int   errors = 0;

  // predictor copy of configuration and state
  logic        a_en = 1'b1;
  logic        b_en = 1'b1;
  logic [4:0]  res_bits = RES_BITS_RST;
  logic [15:0] brake_dly = BRAKE_DLY_RST;
  logic        brake_wait = 1'b0;
  logic [31:0] relay_t0 = 32'd0;
  logic [19:0] held_duty = 20'd0;

  bridge_out_t bridge_out_q[$];

  hbridge_brake_relay_driver_top #(.MAX_DUTY_BITS(MAX_DUTY_BITS)) u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_addr   (cfg_addr),
    .cfg_wdata  (cfg_wdata),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),   // duty_q8, now_ms
    .in_tuser   (in_tuser),   // motor_state
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)   // pin_a_level, pin_b_level, relay_on, pwm_duty, duty_updated
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #5_000_000;
    $display("FAILURE");
    $finish;
  end

  function automatic bridge_out_t predict_bridge_outputs(logic [1:0] st_in,
                                                         logic signed [15:0] duty,
                                                         logic [31:0] now);
    bridge_out_t r;
    logic [1:0]  st;
    int          dv;
    logic [4:0]  bits;
    logic [20:0] mx;
    logic [19:0] scaled;
    logic [31:0] elapsed;
    logic        upd;
    st = st_in;
    dv = duty;
    bits = (res_bits > MAX_DUTY_BITS) ? 5'(MAX_DUTY_BITS) : res_bits;
    mx = (21'd1 << bits) - 21'd1;
    if (dv > int'(FULL_SCALE_Q8)) begin
      scaled = mx[19:0];
    end else if (dv <= 0) begin
      st = ST_IDLE;
      scaled = 20'd0;
    end else begin
      scaled = 20'((longint'(dv) * longint'(mx)) / longint'(FULL_SCALE_Q8));
    end
    if (st != ST_BRAKE) brake_wait = 1'b0;
    r.pin_a = a_en;
    r.pin_b = b_en;
    upd = 1'b0;
    case (st)
      ST_IDLE: begin
        upd = 1'b1;
      end
      ST_BRAKE: begin
        if (!brake_wait) begin
          brake_wait = 1'b1;
          relay_t0 = now;
        end else begin
          elapsed = now - relay_t0;
          if (elapsed > {16'd0, brake_dly}) begin
            r.pin_a = !a_en;
            r.pin_b = !b_en;
            upd = 1'b1;
          end
        end
      end
      ST_FWD: begin
        r.pin_b = !b_en;
        upd = 1'b1;
      end
      default: begin
        r.pin_a = !a_en;
        upd = 1'b1;
      end
    endcase
    if (upd) held_duty = scaled;
    r.relay = brake_wait;
    r.duty = held_duty;
    r.upd = upd;
    return r;
  endfunction

  task automatic report_mismatch(string msg);
    $display("%0t: %s", $realtime, msg);
    errors++;
  endtask

  // result checker
  always @(posedge clk) begin
    bridge_out_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (bridge_out_q.size() == 0) begin
        report_mismatch($sformatf("result transaction with nothing pending: %h", out_tdata));
      end else begin
        want = bridge_out_q.pop_front();
        if (out_tdata[0] !== want.pin_a)
          report_mismatch($sformatf("pin_a_level got %b want %b", out_tdata[0], want.pin_a));
        if (out_tdata[1] !== want.pin_b)
          report_mismatch($sformatf("pin_b_level got %b want %b", out_tdata[1], want.pin_b));
        if (out_tdata[2] !== want.relay)
          report_mismatch($sformatf("relay_on got %b want %b", out_tdata[2], want.relay));
        if (out_tdata[22:3] !== want.duty)
          report_mismatch($sformatf("pwm_duty got %h want %h", out_tdata[22:3], want.duty));
        if (out_tdata[23] !== want.upd)
          report_mismatch($sformatf("duty_updated got %b want %b", out_tdata[23], want.upd));
      end
    end
  end

  // receiver with random stalls and requested long hold-offs
  initial begin
    int hold_left;
    int hold_done;
    hold_left = 0;
    hold_done = 0;
    out_tready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_left > 0) begin
        out_tready <= 1'b0;
        hold_left--;
      end else if (hold_req != hold_done) begin
        hold_done = hold_req;
        hold_left = HOLD_CYCLES;
        out_tready <= 1'b0;
      end else begin
        out_tready <= !(idle_on && ($urandom_range(99) < 27));
      end
    end
  end

  task automatic send_cmd(logic [1:0] st, logic signed [15:0] duty, logic [31:0] now);
    while (idle_on && ($urandom_range(99) < 27)) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser <= st;
    in_tdata <= {now, duty};
    do @(posedge clk); while (!in_tready);
    bridge_out_q.push_back(predict_bridge_outputs(st, duty, now));
  endtask

  task automatic settle();
    in_tvalid <= 1'b0;
    while (bridge_out_q.size() != 0) @(posedge clk);
    repeat (6) @(posedge clk);
  endtask

  task automatic apply_cfg(logic a, logic b, logic [4:0] res, logic [15:0] dly);
    settle();
    cfg_we <= 1'b1;
    cfg_addr <= CFG_A_EN_LEVEL;
    cfg_wdata <= {15'd0, a};
    @(posedge clk);
    cfg_addr <= CFG_B_EN_LEVEL;
    cfg_wdata <= {15'd0, b};
    @(posedge clk);
    cfg_addr <= CFG_DUTY_RES;
    cfg_wdata <= {11'd0, res};
    @(posedge clk);
    cfg_addr <= CFG_BRAKE_DLY;
    cfg_wdata <= dly;
    @(posedge clk);
    cfg_we <= 1'b0;
    a_en = a;
    b_en = b;
    res_bits = res;
    brake_dly = dly;
  endtask

  function automatic logic signed [15:0] pick_duty();
    case ($urandom_range(9))
      0: begin
        case ($urandom_range(6))
          0: return 16'sd0;
          1: return 16'sd1;
          2: return FULL_SCALE_Q8;
          3: return FULL_SCALE_Q8 + 16'sd1;
          4: return -16'sd1;
          5: return 16'sh8000;
          default: return 16'sh7fff;
        endcase
      end
      1, 2: return 16'($urandom());
      default: return 16'($urandom_range(1, 25600));
    endcase
  endfunction

  task automatic brake_run(output int sent);
    logic [31:0]        t;
    logic signed [15:0] duty;
    int                 n;
    n = $urandom_range(2, 6);
    t = $urandom();
    for (int i = 0; i < n; i++) begin
      duty = ($urandom_range(9) == 0) ? pick_duty() : 16'($urandom_range(1, 32767));
      send_cmd(ST_BRAKE, duty, t);
      case ($urandom_range(4))
        0: t = t + brake_dly;
        1: t = t + brake_dly + 32'd1;
        2: t = t + $urandom_range(0, brake_dly);
        default: t = t + $urandom_range(0, 2 * brake_dly + 2);
      endcase
    end
    sent = n;
  endtask

  task automatic random_mix(int count);
    int sent;
    int k;
    sent = 0;
    while (sent < count) begin
      if ($urandom_range(99) < 55) begin
        brake_run(k);
        sent += k;
      end else begin
        send_cmd(2'($urandom_range(3)), pick_duty(), $urandom());
        sent++;
      end
    end
  endtask

  task automatic test_directed();
    send_cmd(ST_IDLE, 16'sd0, 32'd0);
    send_cmd(ST_FWD, FULL_SCALE_Q8, 32'hffff_ffff);
    send_cmd(ST_REV, 16'sh7fff, 32'd1);
    send_cmd(ST_FWD, FULL_SCALE_Q8 + 16'sd1, 32'd2);
    send_cmd(ST_REV, 16'sd1, 32'd3);
    send_cmd(ST_FWD, 16'sd256, 32'd4);
    send_cmd(ST_FWD, -16'sd1, 32'd5);
    send_cmd(ST_REV, 16'sh8000, 32'd6);
    // relay settles, boundary of the delay, then brake applied
    send_cmd(ST_BRAKE, 16'sd12800, 32'd1000);
    send_cmd(ST_BRAKE, 16'sd12800, 32'd1300);
    send_cmd(ST_BRAKE, 16'sd12800, 32'd1301);
    send_cmd(ST_BRAKE, 16'sd6400, 32'd5000);
    send_cmd(ST_FWD, 16'sd100, 32'd5001);
    // elapsed time across the wrap
    send_cmd(ST_BRAKE, FULL_SCALE_Q8, 32'hffff_ff00);
    send_cmd(ST_BRAKE, FULL_SCALE_Q8, 32'h0000_0100);
    send_cmd(ST_BRAKE, 16'sd0, 32'h0000_0200);
    send_cmd(ST_BRAKE, FULL_SCALE_Q8, 32'd0);
    send_cmd(ST_IDLE, FULL_SCALE_Q8, 32'd10);
    send_cmd(ST_BRAKE, 16'sd7, 32'd20);
    send_cmd(ST_BRAKE, 16'sd7, 32'd20);
    send_cmd(ST_REV, 16'sh4000, 32'h8000_0000);
  endtask

  task automatic test_config_extremes();
    apply_cfg(1'b0, 1'b0, 5'd0, 16'd0);
    random_mix(60);
    apply_cfg(1'b1, 1'b0, 5'd1, 16'hffff);
    random_mix(60);
    apply_cfg(1'b0, 1'b1, 5'd20, 16'd1);
    random_mix(60);
    apply_cfg(1'b1, 1'b1, 5'd21, 16'd300);
    random_mix(60);
    apply_cfg(1'b0, 1'b0, 5'd31, 16'd7);
    random_mix(60);
    apply_cfg(1'b1, 1'b1, 5'd8, 16'd0);
    random_mix(60);
    apply_cfg(1'b0, 1'b1, 5'd16, 16'hffff);
    random_mix(60);
  endtask

  task automatic test_no_idle();
    apply_cfg(1'b1, 1'b0, 5'd13, 16'd50);
    idle_on <= 1'b0;
    random_mix(120);
    settle();
    idle_on <= 1'b1;
  endtask

  task automatic test_backpressure();
    apply_cfg(1'b1, 1'b1, 5'd12, 16'd20);
    hold_req <= hold_req + 1;
    random_mix(40);
  endtask

  task automatic test_random_settings();
    for (int p = 0; p < 3; p++) begin
      apply_cfg(1'($urandom_range(1)), 1'($urandom_range(1)), 5'($urandom_range(31)),
                16'($urandom_range(0, 1000)));
      random_mix(80);
    end
  endtask

  initial begin
    rst_n <= 1'b0;
    in_tvalid <= 1'b0;
    in_tdata <= '0;
    in_tuser <= '0;
    cfg_we <= 1'b0;
    cfg_addr <= '0;
    cfg_wdata <= '0;
    idle_on <= 1'b1;
    hold_req <= 0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    test_config_extremes();
    test_no_idle();
    test_backpressure();
    test_random_settings();
    settle();
    if (bridge_out_q.size() != 0)
      report_mismatch($sformatf("%0d results never arrived", bridge_out_q.size()));
    if (errors == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

### filelist.f
design/hbrd_pkg.sv
design/hbrd_duty_pre.sv
design/hbrd_div100.sv
design/hbrd_brake_ctrl.sv
design/hbridge_brake_relay_driver_top.sv
tb/hbridge_brake_relay_driver_top_tb.sv
